// ===== hw/rtl/y2r_pkg.sv =====
// shared constants, types and clamp function for the yuv 4:2:0 to rgb converter
`default_nettype none

package y2r_pkg;

	localparam int PIX_W  = 8;
	localparam int LANES  = 4;
	localparam int FRAC_W = 16;
	localparam int OFF_W  = PIX_W + 1;
	localparam int SUM_W  = 27;

	localparam logic signed [SUM_W-1:0] LUMA_GAIN = 27'sd76309;
	localparam logic signed [SUM_W-1:0] CR_TO_R   = 27'sd104597;
	localparam logic signed [SUM_W-1:0] CB_TO_G   = 27'sd25675;
	localparam logic signed [SUM_W-1:0] CR_TO_G   = 27'sd53279;
	localparam logic signed [SUM_W-1:0] CB_TO_B   = 27'sd132201;
	localparam logic signed [OFF_W-1:0] LUMA_BLACK = 9'sd16;

	localparam logic [PIX_W-1:0] PIX_MIN = '0;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [OFF_W-1:0] off_t;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} pix_t;

	typedef struct packed {
		sum_t r;
		sum_t g;
		sum_t b;
	} chroma_t;

	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
	} stage_ctl_t;

	// floor shift by the fraction bits, then saturate to a byte
	function automatic logic [PIX_W-1:0] shift_clamp(input sum_t s);
		logic [PIX_W-1:0] res;
		priority if (s[SUM_W-1]) begin
			res = PIX_MIN;
		end else if (|s[SUM_W-2:FRAC_W+PIX_W]) begin
			res = PIX_MAX;
		end else begin
			res = s[FRAC_W+PIX_W-1:FRAC_W];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/y2r_if.sv =====
// valid/ready channel interfaces for the yuv block word and the rgb block word
`default_nettype none

interface y2r_yuv_if;
	import y2r_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] luma_top_left;
	logic [PIX_W-1:0] luma_top_right;
	logic [PIX_W-1:0] luma_bottom_left;
	logic [PIX_W-1:0] luma_bottom_right;
	logic [PIX_W-1:0] u_sample;
	logic [PIX_W-1:0] v_sample;

	modport source (
		output valid, luma_top_left, luma_top_right, luma_bottom_left,
		       luma_bottom_right, u_sample, v_sample,
		input  ready
	);

	modport sink (
		input  valid, luma_top_left, luma_top_right, luma_bottom_left,
		       luma_bottom_right, u_sample, v_sample,
		output ready
	);
endinterface

interface y2r_rgb_if;
	import y2r_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_top_left;
	logic [PIX_W-1:0] green_top_left;
	logic [PIX_W-1:0] blue_top_left;
	logic [PIX_W-1:0] red_top_right;
	logic [PIX_W-1:0] green_top_right;
	logic [PIX_W-1:0] blue_top_right;
	logic [PIX_W-1:0] red_bottom_left;
	logic [PIX_W-1:0] green_bottom_left;
	logic [PIX_W-1:0] blue_bottom_left;
	logic [PIX_W-1:0] red_bottom_right;
	logic [PIX_W-1:0] green_bottom_right;
	logic [PIX_W-1:0] blue_bottom_right;

	modport source (
		output valid, red_top_left, green_top_left, blue_top_left,
		       red_top_right, green_top_right, blue_top_right,
		       red_bottom_left, green_bottom_left, blue_bottom_left,
		       red_bottom_right, green_bottom_right, blue_bottom_right,
		input  ready
	);

	modport sink (
		input  valid, red_top_left, green_top_left, blue_top_left,
		       red_top_right, green_top_right, blue_top_right,
		       red_bottom_left, green_bottom_left, blue_bottom_left,
		       red_bottom_right, green_bottom_right, blue_bottom_right,
		output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/y2r_chroma.sv =====
// shared chroma terms of one block, two pipeline stages
`default_nettype none

module y2r_chroma (
	input  wire logic                    clk,
	input  wire y2r_pkg::stage_ctl_t     ctl,
	input  wire logic [y2r_pkg::PIX_W-1:0] u_sample,
	input  wire logic [y2r_pkg::PIX_W-1:0] v_sample,
	output y2r_pkg::chroma_t             chroma_s2
);
	import y2r_pkg::*;

	logic signed [PIX_W-1:0] u_off;
	logic signed [PIX_W-1:0] v_off;
	sum_t r_prod_s1;
	sum_t cbg_prod_s1;
	sum_t crg_prod_s1;
	sum_t b_prod_s1;

	// flipping the top bit takes off the offset of 128
	assign u_off = {~u_sample[PIX_W-1], u_sample[PIX_W-2:0]};
	assign v_off = {~v_sample[PIX_W-1], v_sample[PIX_W-2:0]};

	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			r_prod_s1   <= CR_TO_R * SUM_W'(v_off);
			cbg_prod_s1 <= CB_TO_G * SUM_W'(u_off);
			crg_prod_s1 <= CR_TO_G * SUM_W'(v_off);
			b_prod_s1   <= CB_TO_B * SUM_W'(u_off);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			chroma_s2.r <= r_prod_s1;
			chroma_s2.g <= cbg_prod_s1 + crg_prod_s1;
			chroma_s2.b <= b_prod_s1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/y2r_lane.sv =====
// one pixel lane: luma product, channel sums, shift and clamp
`default_nettype none

module y2r_lane (
	input  wire logic                      clk,
	input  wire y2r_pkg::stage_ctl_t       ctl,
	input  wire logic [y2r_pkg::PIX_W-1:0] luma,
	input  wire y2r_pkg::chroma_t          chroma_s2,
	output y2r_pkg::pix_t                  pix_s4
);
	import y2r_pkg::*;

	off_t luma_off;
	sum_t luma_s1;
	sum_t luma_s2;
	sum_t r_sum_s3;
	sum_t g_sum_s3;
	sum_t b_sum_s3;

	assign luma_off = $signed({1'b0, luma}) - LUMA_BLACK;

	always_ff @(posedge clk) begin
		if (ctl.adv_s1) begin
			luma_s1 <= LUMA_GAIN * SUM_W'(luma_off);
		end
		if (ctl.adv_s2) begin
			luma_s2 <= luma_s1;
		end
		if (ctl.adv_s3) begin
			r_sum_s3 <= luma_s2 + chroma_s2.r;
			g_sum_s3 <= luma_s2 - chroma_s2.g;
			b_sum_s3 <= luma_s2 + chroma_s2.b;
		end
		if (ctl.adv_s4) begin
			pix_s4.r <= shift_clamp(r_sum_s3);
			pix_s4.g <= shift_clamp(g_sum_s3);
			pix_s4.b <= shift_clamp(b_sum_s3);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/yuv420_block_to_rgb_top.sv =====
// top level: an accepted yuv word is registered through stages s1, s2, s3 and s4 to the valid rgb word
// throughput one 2x2 block per cycle while rgb.ready is high, four luma lanes and one shared chroma unit
// each stage holds only while it is full and the stage after it is stalled
// arst_n clears the stage valid bits only; datapath registers are not reset
`default_nettype none

module yuv420_block_to_rgb_top (
	input  wire logic clk,
	input  wire logic arst_n,
	y2r_yuv_if.sink   yuv,
	y2r_rgb_if.source rgb
);
	import y2r_pkg::*;

	logic       v_s1;
	logic       v_s2;
	logic       v_s3;
	logic       v_s4;
	stage_ctl_t ctl;
	chroma_t    chroma_s2;
	logic [PIX_W-1:0] luma [LANES];
	pix_t       pix [LANES];

	// stall chain from the output back to the input
	assign ctl.adv_s4 = !v_s4 || rgb.ready;
	assign ctl.adv_s3 = !v_s3 || ctl.adv_s4;
	assign ctl.adv_s2 = !v_s2 || ctl.adv_s3;
	assign ctl.adv_s1 = !v_s1 || ctl.adv_s2;
	assign yuv.ready  = ctl.adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.adv_s1) begin
				v_s1 <= yuv.valid;
			end
			if (ctl.adv_s2) begin
				v_s2 <= v_s1;
			end
			if (ctl.adv_s3) begin
				v_s3 <= v_s2;
			end
			if (ctl.adv_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign luma[0] = yuv.luma_top_left;
	assign luma[1] = yuv.luma_top_right;
	assign luma[2] = yuv.luma_bottom_left;
	assign luma[3] = yuv.luma_bottom_right;

	y2r_chroma u_chroma (
		.clk       (clk),
		.ctl       (ctl),
		.u_sample  (yuv.u_sample),
		.v_sample  (yuv.v_sample),
		.chroma_s2 (chroma_s2)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		y2r_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.luma      (luma[i]),
			.chroma_s2 (chroma_s2),
			.pix_s4    (pix[i])
		);
	end

	// merge lane results into the rgb word
	assign rgb.valid              = v_s4;
	assign rgb.red_top_left       = pix[0].r;
	assign rgb.green_top_left     = pix[0].g;
	assign rgb.blue_top_left      = pix[0].b;
	assign rgb.red_top_right      = pix[1].r;
	assign rgb.green_top_right    = pix[1].g;
	assign rgb.blue_top_right     = pix[1].b;
	assign rgb.red_bottom_left    = pix[2].r;
	assign rgb.green_bottom_left  = pix[2].g;
	assign rgb.blue_bottom_left   = pix[2].b;
	assign rgb.red_bottom_right   = pix[3].r;
	assign rgb.green_bottom_right = pix[3].g;
	assign rgb.blue_bottom_right  = pix[3].b;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && !rgb.ready |-> !yuv.ready)
		else $error("input taken while every stage is full and output stalled");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		yuv.valid && yuv.ready |=> v_s1)
		else $error("accepted word missing from first stage");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> yuv.ready)
		else $error("input stalled with first stage empty");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && ctl.adv_s4 |=> v_s4)
		else $error("word lost between third stage and output");

endmodule

`default_nettype wire

// ===== tb/tb_yuv420_block_to_rgb_top.sv =====
// self-checking testbench for the yuv 4:2:0 block to rgb24 converter
module tb_yuv420_block_to_rgb_top;
	import y2r_pkg::PIX_W;
	import y2r_pkg::pix_t;

	localparam int Y_SCALE    = 76309;
	localparam int V_TO_RED   = 104597;
	localparam int U_TO_GREEN = 25675;
	localparam int V_TO_GREEN = 53279;
	localparam int U_TO_BLUE  = 132201;
	localparam int Y_FLOOR    = 16;
	localparam int C_ZERO     = 128;
	localparam int SCALE_BITS = 16;

	localparam int RANDOM_BLOCKS = 1700;
	localparam int PRESSURE_AT   = 400;
	localparam int PRESSURE_LEN  = 80;
	localparam int IDLE_LIMIT    = 2000;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct packed {
		logic [3:0][PIX_W-1:0] luma;
		logic [PIX_W-1:0]      u;
		logic [PIX_W-1:0]      v;
	} yuv_word_t;

	typedef pix_t [3:0] rgb_block_t;

	class rgb_scoreboard;
		rgb_block_t  expected_rgb[$];
		int unsigned mismatches;
		string       pixel_name[4];

		function new();
			mismatches = 0;
			pixel_name[0] = "top_left";
			pixel_name[1] = "top_right";
			pixel_name[2] = "bottom_left";
			pixel_name[3] = "bottom_right";
		endfunction

		function logic [PIX_W-1:0] descale_clamp(input int sum);
			int q;
			q = sum >>> SCALE_BITS;
			if (q < 0) begin
				return 8'd0;
			end
			if (q > 255) begin
				return 8'd255;
			end
			return q[PIX_W-1:0];
		endfunction

		function rgb_block_t convert_block(input yuv_word_t w);
			rgb_block_t res;
			int cb;
			int cr;
			int lum;
			cb = int'(w.u) - C_ZERO;
			cr = int'(w.v) - C_ZERO;
			for (int p = 0; p < 4; p++) begin
				lum = Y_SCALE * (int'(w.luma[p]) - Y_FLOOR);
				res[p].r = descale_clamp(lum + V_TO_RED * cr);
				res[p].g = descale_clamp(lum - U_TO_GREEN * cb - V_TO_GREEN * cr);
				res[p].b = descale_clamp(lum + U_TO_BLUE * cb);
			end
			return res;
		endfunction

		function void note_block(input yuv_word_t w);
			expected_rgb.push_back(convert_block(w));
		endfunction

		function void report(input string what, input int p, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
			$display("%0t: %s %s expected %0d actual %0d", $time, what, pixel_name[p],
				want, got);
			mismatches++;
		endfunction

		function void check_block(input rgb_block_t got);
			rgb_block_t want;
			if (expected_rgb.size() == 0) begin
				$display("%0t: unexpected rgb word expected none actual %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_rgb.pop_front();
			for (int p = 0; p < 4; p++) begin
				if (got[p].r !== want[p].r) report("red", p, want[p].r, got[p].r);
				if (got[p].g !== want[p].g) report("green", p, want[p].g, got[p].g);
				if (got[p].b !== want[p].b) report("blue", p, want[p].b, got[p].b);
			end
		endfunction

		function int pending();
			return expected_rgb.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   blocks_in;

	y2r_yuv_if yuv ();
	y2r_rgb_if rgb ();

	yuv420_block_to_rgb_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.yuv    (yuv),
		.rgb    (rgb)
	);

	rgb_scoreboard sb = new();
	yuv_word_t     stimulus_blocks[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic yuv_word_t make_block(input logic [7:0] tl, tr, bl, br, u, v);
		yuv_word_t w;
		w.luma[0] = tl;
		w.luma[1] = tr;
		w.luma[2] = bl;
		w.luma[3] = br;
		w.u       = u;
		w.v       = v;
		return w;
	endfunction

	function automatic logic [7:0] corner_byte();
		logic [7:0] picks[11];
		picks = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128, 8'd129, 8'd235,
			8'd254, 8'd255};
		return picks[$urandom_range(10)];
	endfunction

	function automatic yuv_word_t random_block();
		yuv_word_t w;
		int mode;
		mode = $urandom_range(99);
		w = 48'({$urandom, $urandom});
		if (mode >= 85) begin
			for (int p = 0; p < 4; p++) w.luma[p] = corner_byte();
			w.u = corner_byte();
			w.v = corner_byte();
		end else if (mode >= 70) begin
			for (int p = 0; p < 4; p++) w.luma[p] = 8'($urandom_range(235, 16));
			w.u = 8'($urandom_range(136, 120));
			w.v = 8'($urandom_range(136, 120));
		end
		return w;
	endfunction

	task automatic send_block(input yuv_word_t w);
		yuv.valid             <= 1'b1;
		yuv.luma_top_left     <= w.luma[0];
		yuv.luma_top_right    <= w.luma[1];
		yuv.luma_bottom_left  <= w.luma[2];
		yuv.luma_bottom_right <= w.luma[3];
		yuv.u_sample          <= w.u;
		yuv.v_sample          <= w.v;
		@(posedge clk);
		while (!yuv.ready) @(posedge clk);
	endtask

	task automatic idle_source(input int cycles);
		yuv_word_t noise;
		noise = 48'({$urandom, $urandom});
		yuv.valid             <= 1'b0;
		yuv.luma_top_left     <= noise.luma[0];
		yuv.luma_top_right    <= noise.luma[1];
		yuv.luma_bottom_left  <= noise.luma[2];
		yuv.luma_bottom_right <= noise.luma[3];
		yuv.u_sample          <= noise.u;
		yuv.v_sample          <= noise.v;
		repeat (cycles) @(posedge clk);
	endtask

	// input and output monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (yuv.valid && yuv.ready) begin
				sb.note_block(make_block(yuv.luma_top_left, yuv.luma_top_right,
					yuv.luma_bottom_left, yuv.luma_bottom_right, yuv.u_sample,
					yuv.v_sample));
				blocks_in++;
			end
			if (rgb.valid && rgb.ready) begin
				sb.check_block({
					{rgb.red_bottom_right, rgb.green_bottom_right, rgb.blue_bottom_right},
					{rgb.red_bottom_left, rgb.green_bottom_left, rgb.blue_bottom_left},
					{rgb.red_top_right, rgb.green_top_right, rgb.blue_top_right},
					{rgb.red_top_left, rgb.green_top_left, rgb.blue_top_left}});
			end
		end
	end

	// receiver: stall rate changes per phase, one long hold-off to back the pipe up
	initial begin : rgb_sink
		int stall_pct;
		int phase_left;
		int hold_left;
		bit pressure_done;
		stall_pct     = 0;
		phase_left    = 0;
		hold_left     = 0;
		pressure_done = 1'b0;
		rgb.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!pressure_done && blocks_in >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left     = PRESSURE_LEN;
			end
			if (phase_left == 0) begin
				case ($urandom_range(3))
					0: stall_pct = 0;
					1: stall_pct = 10;
					2: stall_pct = 35;
					default: stall_pct = 70;
				endcase
				phase_left = $urandom_range(300, 50);
			end
			phase_left--;
			if (hold_left > 0) begin
				hold_left--;
				rgb.ready <= 1'b0;
			end else begin
				rgb.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((yuv.valid && yuv.ready) || (rgb.valid && rgb.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		int idx;
		int burst;
		blocks_in = 0;
		arst_n                <= 1'b0;
		yuv.valid             <= 1'b0;
		yuv.luma_top_left     <= '0;
		yuv.luma_top_right    <= '0;
		yuv.luma_bottom_left  <= '0;
		yuv.luma_bottom_right <= '0;
		yuv.u_sample          <= '0;
		yuv.v_sample          <= '0;

		// black/white levels, chroma extremes, clamping and floor rounding near black
		stimulus_blocks.push_back(make_block(0, 0, 0, 0, 0, 0));
		stimulus_blocks.push_back(make_block(255, 255, 255, 255, 255, 255));
		stimulus_blocks.push_back(make_block(16, 16, 16, 16, 128, 128));
		stimulus_blocks.push_back(make_block(235, 235, 235, 235, 128, 128));
		stimulus_blocks.push_back(make_block(0, 255, 16, 235, 0, 0));
		stimulus_blocks.push_back(make_block(0, 255, 16, 235, 255, 255));
		stimulus_blocks.push_back(make_block(0, 255, 16, 235, 0, 255));
		stimulus_blocks.push_back(make_block(0, 255, 16, 235, 255, 0));
		stimulus_blocks.push_back(make_block(15, 17, 127, 128, 128, 128));
		stimulus_blocks.push_back(make_block(128, 128, 128, 128, 127, 129));
		stimulus_blocks.push_back(make_block(81, 145, 41, 210, 90, 240));
		stimulus_blocks.push_back(make_block(255, 0, 255, 0, 128, 0));
		stimulus_blocks.push_back(make_block(1, 254, 2, 253, 1, 254));
		stimulus_blocks.push_back(make_block(170, 85, 170, 85, 85, 170));
		stimulus_blocks.push_back(make_block(85, 170, 85, 170, 170, 85));
		for (int i = 0; i < RANDOM_BLOCKS; i++) stimulus_blocks.push_back(random_block());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		idx = 0;
		while (idx < stimulus_blocks.size()) begin
			burst = $urandom_range(16, 1);
			while (burst > 0 && idx < stimulus_blocks.size()) begin
				send_block(stimulus_blocks[idx]);
				idx++;
				burst--;
			end
			if ($urandom_range(3) != 0) begin
				idle_source($urandom_range(12, 1));
			end
		end
		yuv.valid <= 1'b0;

		// let the monitor note the last accepted word first
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/y2r_pkg.sv
hw/rtl/y2r_if.sv
hw/rtl/y2r_chroma.sv
hw/rtl/y2r_lane.sv
hw/rtl/yuv420_block_to_rgb_top.sv
tb/tb_yuv420_block_to_rgb_top.sv
